FILE: rtl/static_list_table_engine_top_macros.svh
// Assertion macros shared by the list table engine RTL.
`ifndef STATIC_LIST_TABLE_ENGINE_TOP_MACROS_SVH
`define STATIC_LIST_TABLE_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SLTBL_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SLTBL_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SLTBL_CHECK(name, prop, msg)
`define SLTBL_CHECK_NEXT(name, ante, cons, msg)
`endif
`endif

FILE: rtl/sltbl_pkg.sv
// Package with the payload types and operation codes of the list table engine.
package sltbl_pkg;
  localparam int OP_W  = 2;
  localparam int KEY_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  typedef logic [OP_W-1:0]         op_t;
  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_INSERT = 2'd1;
  localparam op_t OP_SEARCH = 2'd2;
  localparam op_t OP_REMOVE = 2'd3;
endpackage

FILE: rtl/sltbl_req_if.sv
// Request channel carrying one operation and its key.
interface sltbl_req_if;
  logic              valid;
  logic              ready;
  sltbl_pkg::op_t    operation;
  sltbl_pkg::key_t   key;

  modport source (output valid, output operation, output key, input ready);
  modport sink (input valid, input operation, input key, output ready);
endinterface

FILE: rtl/sltbl_rsp_if.sv
// Response channel carrying the status of one completed request.
interface sltbl_rsp_if;
  logic            valid;
  logic            ready;
  logic            success;
  logic            found;
  sltbl_pkg::pos_t position;
  sltbl_pkg::cnt_t count;
  logic            empty_res;
  logic            full_res;

  modport source (output valid, output success, output found, output position,
                  output count, output empty_res, output full_res, input ready);
  modport sink (input valid, input success, input found, input position,
                input count, input empty_res, input full_res, output ready);
endinterface

FILE: rtl/sltbl_mem.sv
// Single-port-write, single-port-read key memory with registered read data.
module sltbl_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [sltbl_pkg::KEY_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [sltbl_pkg::KEY_W-1:0] rd_data
);
  logic [sltbl_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

FILE: rtl/static_list_table_engine_top.sv
// Top level of the list table engine: sequencer around the key memory.
//
// The block holds a packed list of up to DEPTH signed 32-bit keys. Each request
// on req carries an operation (append, sorted insert, search, remove first
// match) and a key; each request yields exactly one response on rsp with the
// success and found flags, the match position and the count, empty and full
// status after the operation. A failed operation leaves the list unchanged.
// One request is worked on at a time, and req.ready is high only while the
// sequencer waits for work. Append writes at the end of the list without a
// walk; search, remove and sorted insert walk the list through the one memory
// read port, one entry per cycle. The response sits in an output register; if
// rsp.ready is low, the next request is still accepted and worked on, and the
// block holds the following result until the output register is free. A
// synchronous reset empties the list at once; the memory contents need no
// clearing.
module static_list_table_engine_top #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  sltbl_req_if.sink   req,
  sltbl_rsp_if.source rsp
);
  `include "static_list_table_engine_top_macros.svh"

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_START   = 3'd1;
  localparam logic [2:0] S_INS     = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_SRCH    = 3'd4;
  localparam logic [2:0] S_SHIFT   = 3'd5;
  localparam logic [2:0] S_FINISH  = 3'd6;

  logic [2:0]            state, state_next;
  sltbl_pkg::op_t        op;
  sltbl_pkg::key_t       key;
  logic [CW-1:0]         cnt, cnt_next;
  logic [IW-1:0]         idx, idx_next;
  logic                  success, success_next;
  logic                  found, found_next;
  logic [IW-1:0]         pos, pos_next;

  logic                  out_valid;
  logic                  out_success;
  logic                  out_found;
  logic [IW-1:0]         out_pos;
  logic [CW-1:0]         out_cnt;

  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [sltbl_pkg::KEY_W-1:0] wr_data;
  logic                        rd_en;
  logic [IW-1:0]               rd_addr;
  logic [sltbl_pkg::KEY_W-1:0] rd_data;

  logic                  accept;
  logic                  full;
  logic                  more_after;
  logic                  more_shift;
  logic                  out_free;

  sltbl_mem #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req.ready  = (state == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign full       = (cnt == CW'(DEPTH));
  assign more_after = (CW'(idx) + CW'(1)) < cnt;
  assign more_shift = (CW'(idx) + CW'(2)) < cnt;
  assign out_free   = !out_valid || rsp.ready;

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    idx_next     = idx;
    success_next = success;
    found_next   = found;
    pos_next     = pos;
    wr_en        = 1'b0;
    wr_addr      = idx;
    wr_data      = key;
    rd_en        = 1'b0;
    rd_addr      = idx;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_START;
        end
      end
      S_START: begin
        success_next = 1'b0;
        found_next   = 1'b0;
        pos_next     = '0;
        idx_next     = '0;
        state_next   = S_FINISH;
        unique case (op)
          sltbl_pkg::OP_APPEND, sltbl_pkg::OP_INSERT: begin
            if (!full) begin
              if (op == sltbl_pkg::OP_APPEND || cnt == '0) begin
                wr_en        = 1'b1;
                wr_addr      = IW'(cnt);
                cnt_next     = cnt + CW'(1);
                success_next = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = IW'(cnt - CW'(1));
                idx_next   = IW'(cnt);
                state_next = S_INS;
              end
            end
          end
          sltbl_pkg::OP_SEARCH, sltbl_pkg::OP_REMOVE: begin
            if (cnt != '0) begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              state_next = S_SRCH;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_INS: begin
        if (key < $signed(rd_data)) begin
          wr_en    = 1'b1;
          wr_addr  = idx;
          wr_data  = rd_data;
          idx_next = idx - IW'(1);
          if (idx > IW'(1)) begin
            rd_en   = 1'b1;
            rd_addr = idx - IW'(2);
          end else begin
            state_next = S_INS_PUT;
          end
        end else begin
          wr_en        = 1'b1;
          wr_addr      = idx;
          cnt_next     = cnt + CW'(1);
          success_next = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_INS_PUT: begin
        wr_en        = 1'b1;
        wr_addr      = idx;
        cnt_next     = cnt + CW'(1);
        success_next = 1'b1;
        state_next   = S_FINISH;
      end
      S_SRCH: begin
        if ($signed(rd_data) == key) begin
          success_next = 1'b1;
          found_next   = 1'b1;
          pos_next     = idx;
          if (op == sltbl_pkg::OP_SEARCH) begin
            state_next = S_FINISH;
          end else if (more_after) begin
            rd_en      = 1'b1;
            rd_addr    = idx + IW'(1);
            state_next = S_SHIFT;
          end else begin
            cnt_next   = cnt - CW'(1);
            state_next = S_FINISH;
          end
        end else if (more_after) begin
          rd_en    = 1'b1;
          rd_addr  = idx + IW'(1);
          idx_next = idx + IW'(1);
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = rd_data;
        if (more_shift) begin
          rd_en    = 1'b1;
          rd_addr  = idx + IW'(2);
          idx_next = idx + IW'(1);
        end else begin
          cnt_next   = cnt - CW'(1);
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= req.operation;
      key <= req.key;
    end
    idx     <= idx_next;
    success <= success_next;
    found   <= found_next;
    pos     <= pos_next;
    if (state == S_FINISH && out_free) begin
      out_success <= success;
      out_found   <= found;
      out_pos     <= pos;
      out_cnt     <= cnt;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.success   = out_success;
  assign rsp.found     = out_found;
  assign rsp.position  = sltbl_pkg::POS_W'(out_pos);
  assign rsp.count     = sltbl_pkg::CNT_W'(out_cnt);
  assign rsp.empty_res = (out_cnt == '0);
  assign rsp.full_res  = (out_cnt == CW'(DEPTH));

  `SLTBL_CHECK(a_cnt_bound, cnt <= CW'(DEPTH), "entry count exceeds capacity")
  `SLTBL_CHECK(a_no_write_in_search, !(state == S_SRCH && wr_en), "write during search scan")
  `SLTBL_CHECK_NEXT(a_accept_starts, accept, state == S_START, "accepted request did not start")
  `SLTBL_CHECK_NEXT(a_cnt_steady_idle, state == S_IDLE, cnt == $past(cnt), "count moved while idle")
endmodule

FILE: dv/sltbl_status_checker.sv
// Checker that predicts the list table engine's status for each request and compares responses.
module sltbl_status_checker #(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  sltbl_req_if req,
  sltbl_rsp_if rsp,
  output int   mismatch_count,
  output int   status_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import sltbl_pkg::*;

  typedef struct packed {
    logic success;
    logic found;
    pos_t position;
    cnt_t count;
    logic empty_res;
    logic full_res;
  } list_status_t;

  key_t         list_keys [DEPTH];
  int           list_len;
  list_status_t expected_status_q [$];

  function automatic list_status_t apply_list_op(op_t op, key_t key);
    list_status_t st;
    int           idx;
    int           hit;
    st  = '0;
    hit = -1;
    case (op)
      OP_APPEND, OP_INSERT: begin
        if (list_len < DEPTH) begin
          idx = list_len;
          if (op == OP_INSERT) begin
            while (idx > 0 && key < list_keys[idx-1]) begin
              list_keys[idx] = list_keys[idx-1];
              idx--;
            end
          end
          list_keys[idx] = key;
          list_len++;
          st.success = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < list_len; i++) begin
          if (hit < 0 && list_keys[i] == key) hit = i;
        end
        if (hit >= 0) begin
          if (op == OP_REMOVE) begin
            for (int i = hit; i + 1 < list_len; i++) list_keys[i] = list_keys[i+1];
            list_len--;
          end
          st.success  = 1'b1;
          st.found    = 1'b1;
          st.position = pos_t'(hit);
        end
      end
    endcase
    st.count     = cnt_t'(list_len);
    st.empty_res = (list_len == 0);
    st.full_res  = (list_len == DEPTH);
    return st;
  endfunction

  always @(posedge clk) begin : watch
    list_status_t got;
    list_status_t want;
    if (rst) begin
      list_len       = 0;
      mismatch_count = 0;
      expected_status_q.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_status_q.push_back(apply_list_op(req.operation, req.key));
      end
      if (rsp.valid && rsp.ready) begin
        got = {rsp.success, rsp.found, rsp.position, rsp.count, rsp.empty_res, rsp.full_res};
        if (expected_status_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: response with no request outstanding:", $realtime,
                     " success=%0b found=%0b position=%0d", got.success, got.found,
                     got.position, " count=%0d empty=%0b full=%0b", got.count,
                     got.empty_res, got.full_res);
          end
          mismatch_count++;
        end else begin
          want = expected_status_q.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("%0t: response error: expected", $realtime,
                       " success=%0b found=%0b position=%0d", want.success, want.found,
                       want.position, " count=%0d empty=%0b full=%0b", want.count,
                       want.empty_res, want.full_res);
              $display("%0t:                 got     ", $realtime,
                       " success=%0b found=%0b position=%0d", got.success, got.found,
                       got.position, " count=%0d empty=%0b full=%0b", got.count,
                       got.empty_res, got.full_res);
            end
            mismatch_count++;
          end
        end
      end
    end
    status_pending <= expected_status_q.size();
  end
endmodule

FILE: dv/tb.sv
// Testbench top: clock, reset, request stimulus and response stalls for the list table engine.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sltbl_pkg::*;

  localparam int DEPTH       = 64;
  localparam int NUM_RANDOM  = 1550;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_SORTED} op_mix_e;

  logic clk = 1'b0;
  logic rst;
  bit   quiet_phase;
  int   mismatch_count;
  int   status_pending;
  int   cycle_count;
  key_t wide_keys_q [$];

  sltbl_req_if req_ch ();
  sltbl_rsp_if rsp_ch ();

  static_list_table_engine_top #(.DEPTH(DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  sltbl_status_checker #(.DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .status_pending (status_pending)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic key_t pool_key(int idx);
    case (idx)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return -32'sd1;
      4: return 32'sd1;
      5: return 32'sd2;
      6: return -32'sd2;
      7: return 32'sd16;
      8: return -32'sd16;
      default: return 32'sh0f0f_f0f0;
    endcase
  endfunction

  function automatic op_t pick_op(op_mix_e mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:   return (r < 40) ? OP_APPEND : (r < 85) ? OP_INSERT :
                         (r < 95) ? OP_SEARCH : OP_REMOVE;
      MIX_DRAIN:  return (r < 5) ? OP_APPEND : (r < 15) ? OP_INSERT :
                         (r < 30) ? OP_SEARCH : OP_REMOVE;
      MIX_EVEN:   return (r < 25) ? OP_APPEND : (r < 50) ? OP_INSERT :
                         (r < 75) ? OP_SEARCH : OP_REMOVE;
      default:    return (r < 55) ? OP_INSERT : (r < 80) ? OP_SEARCH : OP_REMOVE;
    endcase
  endfunction

  // Wide random keys sent with appends and inserts are remembered so later searches and removes can hit them.
  function automatic key_t pick_key(op_t op);
    key_t k;
    int   idx;
    if (op == OP_APPEND || op == OP_INSERT) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom;
        wide_keys_q.push_back(k);
      end else begin
        k = pool_key($urandom_range(0, 9));
      end
    end else if (wide_keys_q.size() > 0 && $urandom_range(0, 3) == 0) begin
      idx = $urandom_range(0, wide_keys_q.size() - 1);
      k   = wide_keys_q[idx];
      if (op == OP_REMOVE) wide_keys_q.delete(idx);
    end else if ($urandom_range(0, 9) == 0) begin
      k = $urandom;
    end else begin
      k = pool_key($urandom_range(0, 9));
    end
    return k;
  endfunction

  task automatic issue(input op_t op, input key_t key);
    int gap;
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.key       <= key;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    gap = quiet_phase ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (status_pending != 0) @(negedge clk);
  endtask

  initial begin : receiver
    int stall;
    rsp_ch.ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int      sent;
    int      phase_no;
    int      phase_len;
    op_mix_e mix;
    op_t     op;
    rst              = 1'b1;
    quiet_phase      = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_APPEND;
    req_ch.key       = '0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    issue(OP_SEARCH, 32'sd5);
    issue(OP_REMOVE, 32'sd5);
    issue(OP_APPEND, 32'sd0);
    issue(OP_INSERT, 32'sh8000_0000);
    issue(OP_INSERT, 32'sh7fff_ffff);
    issue(OP_INSERT, -32'sd1);
    issue(OP_INSERT, 32'sd1);
    issue(OP_SEARCH, 32'sh7fff_ffff);
    issue(OP_SEARCH, 32'sd0);
    issue(OP_SEARCH, 32'sd2);
    issue(OP_APPEND, -32'sd5);
    issue(OP_INSERT, 32'sd3);
    issue(OP_APPEND, 32'sd0);
    issue(OP_SEARCH, 32'sd0);
    issue(OP_REMOVE, 32'sd0);
    issue(OP_REMOVE, 32'sh7fff_ffff);
    issue(OP_REMOVE, 32'sh8000_0000);
    issue(OP_REMOVE, 32'sd42);
    issue(OP_INSERT, -32'sd5);
    issue(OP_SEARCH, -32'sd5);
    issue(OP_REMOVE, 32'sd3);
    issue(OP_SEARCH, 32'shffff_0000);
    wait_drained();

    // The first two phases weight the mix toward adds to fill the list and then toward removes to empty it again.
    sent     = 0;
    phase_no = 0;
    while (sent < NUM_RANDOM) begin
      if (phase_no == 0) begin
        mix       = MIX_FILL;
        phase_len = 120;
      end else if (phase_no == 1) begin
        mix       = MIX_DRAIN;
        phase_len = 120;
      end else begin
        mix       = op_mix_e'($urandom_range(0, 3));
        phase_len = $urandom_range(40, 120);
      end
      quiet_phase = ($urandom_range(0, 3) == 0);
      if (phase_no % 6 == 3) wait_drained();
      for (int n = 0; n < phase_len; n++) begin
        op = pick_op(mix);
        issue(op, pick_key(op));
        sent++;
      end
      phase_no++;
    end

    quiet_phase = 1'b0;
    wait_drained();
    repeat (DEPTH + 10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
